[hw/rtl/keyword_lexer_stream_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keyword lexer stream
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_LEXER_STREAM_ASSERT_SVH
`define KEYWORD_LEXER_STREAM_ASSERT_SVH

// expression holds at every clock edge out of reset
`define KLX_ASSERT_ALWAYS(label, clk, rstn, expr) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
		else $error("klx assertion failed");

// antecedent implies consequent on the following edge
`define KLX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("klx assertion failed");

`endif

[hw/rtl/klx_pkg.sv]
// ----------------------------------------------------------------------------
// klx_pkg
// Record layout, codes and keyword table of the keyword lexer.
// ----------------------------------------------------------------------------
package klx_pkg;

	localparam int RecCount  = 4;
	localparam int KwCount   = 25;
	localparam int KwLenMax  = 9;

	localparam logic [1:0] REC_CONTENT  = 2'd0;
	localparam logic [1:0] REC_COMPLETE = 2'd1;
	localparam logic [1:0] REC_ERROR    = 2'd2;

	localparam logic [4:0] KIND_IDENT   = 5'd0;
	localparam logic [4:0] KIND_NUMBER  = 5'd1;
	localparam logic [4:0] KIND_TEXT    = 5'd2;
	localparam logic [4:0] KIND_NEWLINE = 5'd3;
	localparam logic [4:0] KIND_LPAREN  = 5'd4;
	localparam logic [4:0] KIND_RPAREN  = 5'd5;
	localparam logic [4:0] KIND_EOF     = 5'd6;
	localparam logic [4:0] KIND_KW_BASE = 5'd7;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNCLOSED = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	// right-aligned, zero padded above the first letter
	localparam logic [8*KwLenMax-1:0] KW_TEXT [KwCount] = '{
		72'("definir"), 72'("como"), 72'("si"), 72'("entonces"), 72'("sino"),
		72'("fin"), 72'("repetir"), 72'("veces"), 72'("mientras"),
		72'("mostrar"), 72'("mas"), 72'("menos"), 72'("por"), 72'("entre"),
		72'("es"), 72'("mayor"), 72'("menor"), 72'("igual"), 72'("que"),
		72'("a"), 72'("y"), 72'("o"), 72'("no"), 72'("verdadero"),
		72'("falso")
	};

	typedef struct packed {
		logic [1:0]  rtype;
		logic [4:0]  kind;
		logic [1:0]  err;
		logic [15:0] line;
		logic [15:0] col;
		logic [7:0]  data;
	} record_t;

	typedef struct packed {
		logic [2:0]                count;
		record_t [RecCount-1:0]    recs;
	} rec_burst_t;

	function automatic record_t make_rec(input logic [1:0] rtype, input logic [4:0] kind,
			input logic [1:0] err, input logic [15:0] line, input logic [15:0] col,
			input logic [7:0] data);
		record_t r;
		r.rtype = rtype;
		r.kind  = kind;
		r.err   = err;
		r.line  = line;
		r.col   = col;
		r.data  = data;
		return r;
	endfunction

	function automatic logic [4:0] kw_kind(input logic [8*KwLenMax-1:0] word);
		logic [4:0] kind;
		logic       found;
		kind  = KIND_IDENT;
		found = 1'b0;
		for (int i = 0; i < KwCount; i++) begin
			if (!found && word == KW_TEXT[i]) begin
				kind  = 5'(KIND_KW_BASE + 5'(i));
				found = 1'b1;
			end
		end
		return kind;
	endfunction

endpackage

[hw/rtl/klx_stream_if.sv]
// ----------------------------------------------------------------------------
// klx stream interfaces
// Character input channel and token record output channel.
// ----------------------------------------------------------------------------
interface klx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_source;

	modport source (output valid, output char_byte, output end_of_source, input ready);
	modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface klx_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  record_type;
	logic [4:0]  token_kind;
	logic [1:0]  error_code;
	logic [15:0] line_number;
	logic [15:0] column_number;
	logic [7:0]  content_byte;
	logic        last;

	modport source (output valid, output record_type, output token_kind, output error_code,
		output line_number, output column_number, output content_byte, output last,
		input ready);
	modport sink (input valid, input record_type, input token_kind, input error_code,
		input line_number, input column_number, input content_byte, input last,
		output ready);
endinterface

[hw/rtl/keyword_lexer_stream.sv]
// A character enters the s1 register, is scanned, and loads its records into the free
// output bank. Throughput: one character per cycle while each gives at most one record and
// the output is ready; a burst holds the input until the single-record port takes its last.
// Reset: asynchronous, clears scan state to line 1, column 1, idle; no clearing pass.
// ----------------------------------------------------------------------------
// keyword_lexer_stream
// Character stream lexer with keyword table, streaming token records.
// ----------------------------------------------------------------------------
module keyword_lexer_stream #(
	parameter int MAX_KEYWORD_LEN = 9,
	parameter int POSITION_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	klx_in_if.sink     chars,
	klx_out_if.source  tokens
);
	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                eos_s1;
	logic                advance;
	logic                free;
	klx_pkg::rec_burst_t burst;

	assign advance     = valid_s1 && free;
	assign chars.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_byte;
			eos_s1  <= chars.end_of_source;
		end
	end

	klx_scan #(
		.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
		.POSITION_BITS   (POSITION_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.char_byte     (char_s1),
		.end_of_source (eos_s1),
		.burst         (burst)
	);

	klx_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.burst  (burst),
		.free   (free),
		.tokens (tokens)
	);

endmodule

[hw/rtl/klx_scan.sv]
// ----------------------------------------------------------------------------
// klx_scan
// Lexer state and single-pass scan of one character into up to four records.
// ----------------------------------------------------------------------------
`include "keyword_lexer_stream_assert.svh"

module klx_scan #(
	parameter int MAX_KEYWORD_LEN = 9,
	parameter int POSITION_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_source,
	output klx_pkg::rec_burst_t   burst
);
	localparam int LW = $clog2(MAX_KEYWORD_LEN + 2);
	localparam int IW = $clog2(MAX_KEYWORD_LEN);
	localparam int PB = POSITION_BITS;
	localparam int KB = 8 * klx_pkg::KwLenMax;

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_COMMENT = 3'd1;
	localparam logic [2:0] M_WORD    = 3'd2;
	localparam logic [2:0] M_NUMBER  = 3'd3;
	localparam logic [2:0] M_NPOINT  = 3'd4;
	localparam logic [2:0] M_TEXT    = 3'd5;
	localparam logic [2:0] M_ESC     = 3'd6;

	localparam logic [PB-1:0] PosMax = {PB{1'b1}};
	localparam logic [PB-1:0] PosOne = PB'(1);

	logic [2:0]    mode_q, mode_n;
	logic          nhp_q, nhp_n;
	logic [PB-1:0] line_q, line_n, col_q, col_n, tsc_q, tsc_n, pcol_q, pcol_n;
	logic [LW-1:0] wlen_q, wlen_n;
	logic          stopped_q, stopped_n;
	logic [7:0]    wbuf_q [MAX_KEYWORD_LEN];

	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [7:0]    wr_data;

	logic [KB-1:0] word_vec, word_aligned;
	logic [4:0]    word_kind;

	klx_pkg::record_t recs [klx_pkg::RecCount];
	logic [2:0]       n;
	logic             reidle, do_text, do_flush, is_digit, is_alpha, is_word;
	logic [15:0]      line16, col16;

	// pack the first letters MSB first, then align the word to the right
	always_comb begin
		for (int i = 0; i < klx_pkg::KwLenMax; i++) begin
			word_vec[KB-1-8*i -: 8] = wbuf_q[i];
		end
		word_aligned = word_vec >> (8 * (klx_pkg::KwLenMax - int'(wlen_q)));
		if (wlen_q != '0 && wlen_q <= LW'(klx_pkg::KwLenMax))
			word_kind = klx_pkg::kw_kind(word_aligned);
		else
			word_kind = klx_pkg::KIND_IDENT;
	end

	assign is_digit = char_byte >= 8'h30 && char_byte <= 8'h39;
	assign is_alpha = (char_byte >= 8'h61 && char_byte <= 8'h7A) ||
		(char_byte >= 8'h41 && char_byte <= 8'h5A);
	assign is_word  = is_alpha || is_digit || char_byte == klx_pkg::CH_USCORE;
	assign line16   = 16'(line_q);
	assign col16    = 16'(col_q);

	always_comb begin
		mode_n    = mode_q;
		nhp_n     = nhp_q;
		line_n    = line_q;
		col_n     = col_q;
		tsc_n     = tsc_q;
		pcol_n    = pcol_q;
		wlen_n    = wlen_q;
		stopped_n = stopped_q;
		wr_en     = 1'b0;
		wr_idx    = '0;
		wr_data   = (char_byte >= 8'h41 && char_byte <= 8'h5A) ? char_byte + 8'd32 : char_byte;
		n         = 3'd0;
		reidle    = 1'b0;
		do_text   = 1'b0;
		for (int i = 0; i < klx_pkg::RecCount; i++) recs[i] = '0;

		do_flush = !stopped_q && (end_of_source || char_byte == klx_pkg::CH_NUL);

		if (do_flush) begin
			case (mode_q)
				M_WORD: begin
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE, word_kind,
						klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
					n = n + 3'd1;
				end
				M_NUMBER: begin
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE,
						klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
					n = n + 3'd1;
				end
				M_NPOINT: begin
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE,
						klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
					n = n + 3'd1;
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_ERROR, klx_pkg::KIND_IDENT,
						klx_pkg::ERR_UNKNOWN, line16, 16'(pcol_q), klx_pkg::CH_POINT);
					n = n + 3'd1;
				end
				M_TEXT, M_ESC: begin
					if (mode_q == M_ESC) begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_TEXT, klx_pkg::ERR_NONE, line16, 16'(tsc_q),
							klx_pkg::CH_BSLASH);
						n = n + 3'd1;
					end
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_ERROR, klx_pkg::KIND_IDENT,
						klx_pkg::ERR_UNCLOSED, line16, col16, 8'd0);
					n = n + 3'd1;
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE,
						klx_pkg::KIND_TEXT, klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
					n = n + 3'd1;
				end
				default: ;
			endcase
			mode_n = M_IDLE;
		end

		if (end_of_source) begin
			recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE, klx_pkg::KIND_EOF,
				klx_pkg::ERR_NONE, line16, col16, 8'd0);
			n         = n + 3'd1;
			mode_n    = M_IDLE;
			nhp_n     = 1'b0;
			line_n    = PosOne;
			col_n     = PosOne;
			tsc_n     = PosOne;
			pcol_n    = PosOne;
			wlen_n    = '0;
			stopped_n = 1'b0;
		end else if (!stopped_q && char_byte == klx_pkg::CH_NUL) begin
			stopped_n = 1'b1;
		end else if (!stopped_q) begin
			case (mode_q)
				M_COMMENT: begin
					if (char_byte == klx_pkg::CH_LF) begin
						mode_n = M_IDLE;
						reidle = 1'b1;
					end
				end
				M_WORD: begin
					if (is_word) begin
						if (wlen_q < LW'(MAX_KEYWORD_LEN)) begin
							wr_en  = 1'b1;
							wr_idx = wlen_q[IW-1:0];
							wlen_n = wlen_q + LW'(1);
						end else begin
							wlen_n = LW'(MAX_KEYWORD_LEN + 1);
						end
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_IDENT, klx_pkg::ERR_NONE, line16, 16'(tsc_q),
							char_byte);
						n = n + 3'd1;
					end else begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE, word_kind,
							klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
						n      = n + 3'd1;
						mode_n = M_IDLE;
						reidle = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit) begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, 16'(tsc_q),
							char_byte);
						n = n + 3'd1;
					end else if (char_byte == klx_pkg::CH_POINT && !nhp_q) begin
						pcol_n = col_q;
						mode_n = M_NPOINT;
					end else begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE,
							klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
						n      = n + 3'd1;
						mode_n = M_IDLE;
						reidle = 1'b1;
					end
				end
				M_NPOINT: begin
					if (is_digit) begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, 16'(tsc_q),
							klx_pkg::CH_POINT);
						n = n + 3'd1;
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, 16'(tsc_q),
							char_byte);
						n      = n + 3'd1;
						nhp_n  = 1'b1;
						mode_n = M_NUMBER;
					end else begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE,
							klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
						n = n + 3'd1;
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_ERROR,
							klx_pkg::KIND_IDENT, klx_pkg::ERR_UNKNOWN, line16, 16'(pcol_q),
							klx_pkg::CH_POINT);
						n      = n + 3'd1;
						mode_n = M_IDLE;
						reidle = 1'b1;
					end
				end
				M_TEXT: do_text = 1'b1;
				M_ESC: begin
					if (char_byte == klx_pkg::CH_LOW_N || char_byte == klx_pkg::CH_LOW_T) begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_TEXT, klx_pkg::ERR_NONE, line16, 16'(tsc_q),
							(char_byte == klx_pkg::CH_LOW_N) ? klx_pkg::CH_LF : klx_pkg::CH_TAB);
						n = n + 3'd1;
					end else begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_TEXT, klx_pkg::ERR_NONE, line16, 16'(tsc_q),
							klx_pkg::CH_BSLASH);
						n       = n + 3'd1;
						do_text = 1'b1;
					end
					mode_n = M_TEXT;
				end
				default: begin
					mode_n = M_IDLE;
					reidle = 1'b1;
				end
			endcase

			if (do_text) begin
				if (char_byte == klx_pkg::CH_QUOTE) begin
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE, klx_pkg::KIND_TEXT,
						klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
					n      = n + 3'd1;
					mode_n = M_IDLE;
				end else if (char_byte == klx_pkg::CH_LF) begin
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_ERROR, klx_pkg::KIND_IDENT,
						klx_pkg::ERR_UNCLOSED, line16, col16, 8'd0);
					n = n + 3'd1;
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE, klx_pkg::KIND_TEXT,
						klx_pkg::ERR_NONE, line16, 16'(tsc_q), 8'd0);
					n      = n + 3'd1;
					mode_n = M_IDLE;
					reidle = 1'b1;
				end else if (char_byte == klx_pkg::CH_BSLASH) begin
					mode_n = M_ESC;
				end else begin
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT, klx_pkg::KIND_TEXT,
						klx_pkg::ERR_NONE, line16, 16'(tsc_q), char_byte);
					n = n + 3'd1;
				end
			end

			// byte not consumed by the running token starts afresh
			if (reidle) begin
				if (char_byte == klx_pkg::CH_SPACE || char_byte == klx_pkg::CH_TAB ||
						char_byte == klx_pkg::CH_CR) begin
					mode_n = M_IDLE;
				end else if (char_byte == klx_pkg::CH_HASH) begin
					mode_n = M_COMMENT;
				end else if (char_byte == klx_pkg::CH_LF || char_byte == klx_pkg::CH_LPAREN ||
						char_byte == klx_pkg::CH_RPAREN) begin
					recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_COMPLETE,
						(char_byte == klx_pkg::CH_LF) ? klx_pkg::KIND_NEWLINE :
						(char_byte == klx_pkg::CH_LPAREN) ? klx_pkg::KIND_LPAREN :
						klx_pkg::KIND_RPAREN, klx_pkg::ERR_NONE, line16, col16, 8'd0);
					n = n + 3'd1;
				end else begin
					tsc_n = col_q;
					if (is_digit) begin
						mode_n = M_NUMBER;
						nhp_n  = 1'b0;
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_NUMBER, klx_pkg::ERR_NONE, line16, col16, char_byte);
						n = n + 3'd1;
					end else if (char_byte == klx_pkg::CH_QUOTE) begin
						mode_n = M_TEXT;
					end else if (is_alpha || char_byte == klx_pkg::CH_USCORE) begin
						mode_n = M_WORD;
						wr_en  = 1'b1;
						wr_idx = '0;
						wlen_n = LW'(1);
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_CONTENT,
							klx_pkg::KIND_IDENT, klx_pkg::ERR_NONE, line16, col16, char_byte);
						n = n + 3'd1;
					end else begin
						recs[n[1:0]] = klx_pkg::make_rec(klx_pkg::REC_ERROR,
							klx_pkg::KIND_IDENT, klx_pkg::ERR_UNKNOWN, line16, col16, char_byte);
						n = n + 3'd1;
					end
				end
			end

			if (char_byte == klx_pkg::CH_LF) begin
				if (line_q != PosMax) line_n = line_q + PosOne;
				col_n = PosOne;
			end else if (col_q != PosMax) begin
				col_n = col_q + PosOne;
			end
		end
	end

	always_comb begin
		burst.count = n;
		for (int i = 0; i < klx_pkg::RecCount; i++) burst.recs[i] = recs[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			nhp_q     <= 1'b0;
			line_q    <= PosOne;
			col_q     <= PosOne;
			tsc_q     <= PosOne;
			pcol_q    <= PosOne;
			wlen_q    <= '0;
			stopped_q <= 1'b0;
		end else if (advance) begin
			mode_q    <= mode_n;
			nhp_q     <= nhp_n;
			line_q    <= line_n;
			col_q     <= col_n;
			tsc_q     <= tsc_n;
			pcol_q    <= pcol_n;
			wlen_q    <= wlen_n;
			stopped_q <= stopped_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) wbuf_q[wr_idx] <= wr_data;
	end

	`KLX_ASSERT_ALWAYS(a_line_nonzero, clk, arst_n, line_q != '0)
	`KLX_ASSERT_ALWAYS(a_col_nonzero, clk, arst_n, col_q != '0)
	`KLX_ASSERT_ALWAYS(a_stopped_idle, clk, arst_n, !stopped_q || mode_q == M_IDLE)

endmodule

[hw/rtl/klx_outq.sv]
// ----------------------------------------------------------------------------
// klx_outq
// Result register bank: holds one burst of records and hands them out in order.
// ----------------------------------------------------------------------------
`include "keyword_lexer_stream_assert.svh"

module klx_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  klx_pkg::rec_burst_t  burst,
	output logic                 free,
	klx_out_if.source            tokens
);
	klx_pkg::record_t recs_q [klx_pkg::RecCount];
	logic [1:0]       idx_q;
	logic [2:0]       rem_q;
	logic             xfer;

	assign tokens.valid         = rem_q != 3'd0;
	assign xfer                 = tokens.valid && tokens.ready;
	assign free                 = rem_q == 3'd0 || (rem_q == 3'd1 && tokens.ready);
	assign tokens.record_type   = recs_q[idx_q].rtype;
	assign tokens.token_kind    = recs_q[idx_q].kind;
	assign tokens.error_code    = recs_q[idx_q].err;
	assign tokens.line_number   = recs_q[idx_q].line;
	assign tokens.column_number = recs_q[idx_q].col;
	assign tokens.content_byte  = recs_q[idx_q].data;
	assign tokens.last          = rem_q == 3'd1;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < klx_pkg::RecCount; i++) recs_q[i] <= burst.recs[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rem_q <= '0;
		end else if (load) begin
			idx_q <= '0;
			rem_q <= burst.count;
		end else if (xfer) begin
			idx_q <= idx_q + 2'd1;
			rem_q <= rem_q - 3'd1;
		end
	end

	`KLX_ASSERT_ALWAYS(a_rem_bound, clk, arst_n, rem_q <= 3'd4)
	`KLX_ASSERT_ALWAYS(a_load_when_free, clk, arst_n, !load || free)
	`KLX_ASSERT_NEXT(a_drain_step, clk, arst_n, xfer && !load, rem_q == $past(rem_q) - 3'd1)

endmodule
